/* hdl/scc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Swept circle collision package
// Shared payload types, step counts and helpers for the collision pipeline.
// ----------------------------------------------------------------------------
package scc_pkg;

	localparam int ROOT_STEPS = 66;
	localparam int QUO_STEPS  = 34;
	localparam int LEN_STEPS  = 49;
	localparam int UNIT_STEPS = 18;

	localparam logic [18:0] UNIT_ONE = 19'd65536;

	typedef struct packed {
		logic               miss;
		logic               neg_dx;
		logic               neg_dy;
		logic [32:0]        mag_dx;
		logic [32:0]        mag_dy;
		logic signed [31:0] start_x;
		logic signed [31:0] start_y;
		logic signed [31:0] center_x;
		logic signed [31:0] center_y;
		logic [65:0]        len2;
		logic [65:0]        dot;
	} geo_t;

	typedef struct packed {
		geo_t        geo;
		logic [65:0] near;
	} root_t;

	typedef struct packed {
		logic               miss;
		logic               zero;
		logic signed [31:0] contact_x;
		logic signed [31:0] contact_y;
		logic               neg_x;
		logic               neg_y;
		logic [32:0]        mag_x;
		logic [32:0]        mag_y;
	} nrm_t;

	function automatic logic [32:0] mag33(logic signed [32:0] v);
		return v[32] ? 33'(-v) : 33'(v);
	endfunction

endpackage
`default_nettype wire

/* hdl/swept_circle_collision.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Swept circle collision
// Moving circle against a fixed circle along a segment; contact and normal.
// ----------------------------------------------------------------------------
// Usage:
//   Send one query per item on the s_ channel: both circles and the segment,
//   all Q16.16. Each query gives exactly one result item on the m_ channel,
//   in order: m_tuser is the hit flag, m_tdata the contact point and the unit
//   normal, all zero on a miss.
//   Each result passes the front end, the 66-stage discriminant root, the
//   contact divider (34 quotient stages), the normal root (49 stages) and the
//   18-stage normal divider into the result register.
//   Throughput is one item per cycle; every stage is a register stage.
//   When m_tready is low with a result waiting, the whole pipeline holds and
//   s_tready drops; nothing advances, empty slots included, until it is taken.
//   Reset clears all valid bits; the first item can be taken once reset is released.
// ----------------------------------------------------------------------------
module swept_circle_collision (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// center_x, center_y, own_radius, other_radius, start_x, start_y, end_x, end_y
	input  wire logic [255:0] s_tdata,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// contact_x, contact_y, normal_x, normal_y
	output logic [103:0]      m_tdata,
	// hit
	output logic              m_tuser
);

	logic                en;
	logic                fr_valid, rt_valid, ct_valid;
	scc_pkg::geo_t       fr_geo;
	logic [131:0]        fr_disc;
	scc_pkg::root_t      rt_root;
	scc_pkg::nrm_t       ct_nrm;
	logic [65:0]         ct_q;
	logic signed [31:0]  contact_x, contact_y;
	logic signed [17:0]  normal_x, normal_y;

	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	scc_front u_front (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(s_tvalid && s_tready),
		.center_x($signed(s_tdata[31:0])), .center_y($signed(s_tdata[63:32])),
		.own_radius(s_tdata[94:64]), .other_radius(s_tdata[125:95]),
		.start_x($signed(s_tdata[157:126])), .start_y($signed(s_tdata[189:158])),
		.end_x($signed(s_tdata[221:190])), .end_y($signed(s_tdata[253:222])),
		.out_valid(fr_valid), .out_geo(fr_geo), .out_disc(fr_disc)
	);

	scc_root u_root (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(fr_valid),
		.in_geo(fr_geo), .in_disc(fr_disc),
		.out_valid(rt_valid), .out_root(rt_root)
	);

	scc_contact u_contact (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(rt_valid), .in_root(rt_root),
		.out_valid(ct_valid), .out_nrm(ct_nrm), .out_q(ct_q)
	);

	scc_normal u_normal (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(ct_valid),
		.in_nrm(ct_nrm), .in_q(ct_q),
		.out_valid(m_tvalid), .hit(m_tuser),
		.contact_x(contact_x), .contact_y(contact_y),
		.normal_x(normal_x), .normal_y(normal_y)
	);

	assign m_tdata = {4'b0000, normal_y, normal_x, contact_y, contact_x};

endmodule
`default_nettype wire

/* hdl/scc_mul.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Wide multiplier
// 66 x 66 unsigned product from four 33 x 33 partial products, two stages.
// ----------------------------------------------------------------------------
module scc_mul (
	input  wire logic         clk,
	input  wire logic         en,
	input  wire logic [65:0]  x,
	input  wire logic [65:0]  y,
	output logic      [131:0] prod
);

	logic [65:0] ll_s1, lh_s1, hl_s1, hh_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			ll_s1 <= 66'(x[32:0]) * 66'(y[32:0]);
			lh_s1 <= 66'(x[32:0]) * 66'(y[65:33]);
			hl_s1 <= 66'(x[65:33]) * 66'(y[32:0]);
			hh_s1 <= 66'(x[65:33]) * 66'(y[65:33]);
			prod  <= {hh_s1, 66'b0} + 132'({lh_s1, 33'b0}) + 132'({hl_s1, 33'b0})
				+ 132'(ll_s1);
		end
	end

endmodule
`default_nettype wire

/* hdl/scc_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Collision front end
// Direction, quadratic terms, discriminant and the early miss tests.
// ----------------------------------------------------------------------------
module scc_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               en,
	input  wire logic               in_valid,
	input  wire logic signed [31:0] center_x,
	input  wire logic signed [31:0] center_y,
	input  wire logic [30:0]        own_radius,
	input  wire logic [30:0]        other_radius,
	input  wire logic signed [31:0] start_x,
	input  wire logic signed [31:0] start_y,
	input  wire logic signed [31:0] end_x,
	input  wire logic signed [31:0] end_y,
	output logic                    out_valid,
	output scc_pkg::geo_t           out_geo,
	output logic [131:0]            out_disc
);

	logic               v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic signed [31:0] cx_s1, cy_s1, sx_s1, sy_s1;
	logic signed [32:0] dx_s1, dy_s1, rx_s1, ry_s1;
	logic [31:0]        rs_s1;

	logic [32:0]        mdx, mdy, mrx, mry;
	logic signed [31:0] cx_s2, cy_s2, sx_s2, sy_s2;
	logic               ndx_s2, ndy_s2, samex_s2, samey_s2;
	logic [32:0]        mdx_s2, mdy_s2;
	logic [65:0]        pdx_s2, pdy_s2, prx_s2, pry_s2, pxr_s2, pyr_s2;
	logic [63:0]        r2_s2;

	logic signed [31:0] cx_s3, cy_s3, sx_s3, sy_s3;
	logic               ndx_s3, ndy_s3;
	logic [32:0]        mdx_s3, mdy_s3;
	logic [65:0]        a_s3, rel_s3, pos_s3, neg_s3;
	logic [63:0]        r2_s3;

	scc_pkg::geo_t      geo_s4, geo_s5, geo_s6, geo_s7, geo_s8;
	scc_pkg::geo_t      geo_out;
	logic [65:0]        c_s4, c_s5, lim_s5;
	logic               gt_s5, gt_s6, gt_s7, gt_s8;
	logic [131:0]       b2, ac, l2;
	logic [131:0]       disc_s8, l2_s8;
	logic               dneg_s8;

	assign mdx = scc_pkg::mag33(dx_s1);
	assign mdy = scc_pkg::mag33(dy_s1);
	assign mrx = scc_pkg::mag33(rx_s1);
	assign mry = scc_pkg::mag33(ry_s1);

	always_comb begin
		geo_out      = geo_s8;
		geo_out.miss = geo_s8.miss || dneg_s8 || (gt_s8 && (l2_s8 > disc_s8));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			v_s4      <= 1'b0;
			v_s5      <= 1'b0;
			v_s6      <= 1'b0;
			v_s7      <= 1'b0;
			v_s8      <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_s1      <= in_valid;
			v_s2      <= v_s1;
			v_s3      <= v_s2;
			v_s4      <= v_s3;
			v_s5      <= v_s4;
			v_s6      <= v_s5;
			v_s7      <= v_s6;
			v_s8      <= v_s7;
			out_valid <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cx_s1 <= center_x;
			cy_s1 <= center_y;
			sx_s1 <= start_x;
			sy_s1 <= start_y;
			dx_s1 <= 33'(end_x) - 33'(start_x);
			dy_s1 <= 33'(end_y) - 33'(start_y);
			rx_s1 <= 33'(center_x) - 33'(start_x);
			ry_s1 <= 33'(center_y) - 33'(start_y);
			rs_s1 <= 32'(own_radius) + 32'(other_radius);

			cx_s2    <= cx_s1;
			cy_s2    <= cy_s1;
			sx_s2    <= sx_s1;
			sy_s2    <= sy_s1;
			ndx_s2   <= dx_s1[32];
			ndy_s2   <= dy_s1[32];
			samex_s2 <= dx_s1[32] == rx_s1[32];
			samey_s2 <= dy_s1[32] == ry_s1[32];
			mdx_s2   <= mdx;
			mdy_s2   <= mdy;
			pdx_s2   <= 66'(mdx) * 66'(mdx);
			pdy_s2   <= 66'(mdy) * 66'(mdy);
			prx_s2   <= 66'(mrx) * 66'(mrx);
			pry_s2   <= 66'(mry) * 66'(mry);
			pxr_s2   <= 66'(mdx) * 66'(mrx);
			pyr_s2   <= 66'(mdy) * 66'(mry);
			r2_s2    <= 64'(rs_s1) * 64'(rs_s1);

			cx_s3  <= cx_s2;
			cy_s3  <= cy_s2;
			sx_s3  <= sx_s2;
			sy_s3  <= sy_s2;
			ndx_s3 <= ndx_s2;
			ndy_s3 <= ndy_s2;
			mdx_s3 <= mdx_s2;
			mdy_s3 <= mdy_s2;
			a_s3   <= pdx_s2 + pdy_s2;
			rel_s3 <= prx_s2 + pry_s2;
			pos_s3 <= (samex_s2 ? pxr_s2 : 66'd0) + (samey_s2 ? pyr_s2 : 66'd0);
			neg_s3 <= (samex_s2 ? 66'd0 : pxr_s2) + (samey_s2 ? 66'd0 : pyr_s2);
			r2_s3  <= r2_s2;

			geo_s4.miss     <= (rel_s3 < 66'(r2_s3)) || (a_s3 == 66'd0) || (pos_s3 < neg_s3);
			geo_s4.neg_dx   <= ndx_s3;
			geo_s4.neg_dy   <= ndy_s3;
			geo_s4.mag_dx   <= mdx_s3;
			geo_s4.mag_dy   <= mdy_s3;
			geo_s4.start_x  <= sx_s3;
			geo_s4.start_y  <= sy_s3;
			geo_s4.center_x <= cx_s3;
			geo_s4.center_y <= cy_s3;
			geo_s4.len2     <= a_s3;
			geo_s4.dot      <= pos_s3 - neg_s3;
			c_s4            <= rel_s3 - 66'(r2_s3);

			geo_s5 <= geo_s4;
			c_s5   <= c_s4;
			gt_s5  <= geo_s4.dot > geo_s4.len2;
			lim_s5 <= geo_s4.dot - geo_s4.len2;

			geo_s6 <= geo_s5;
			gt_s6  <= gt_s5;
			geo_s7 <= geo_s6;
			gt_s7  <= gt_s6;

			geo_s8  <= geo_s7;
			gt_s8   <= gt_s7;
			disc_s8 <= b2 - ac;
			dneg_s8 <= b2 < ac;
			l2_s8   <= l2;

			out_geo  <= geo_out;
			out_disc <= disc_s8;
		end
	end

	scc_mul u_mul_b2 (.clk(clk), .en(en), .x(geo_s5.dot), .y(geo_s5.dot), .prod(b2));
	scc_mul u_mul_ac (.clk(clk), .en(en), .x(geo_s5.len2), .y(c_s5), .prod(ac));
	scc_mul u_mul_l2 (.clk(clk), .en(en), .x(lim_s5), .y(lim_s5), .prod(l2));

endmodule
`default_nettype wire

/* hdl/scc_root.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Discriminant square root
// Two radicand bits per stage, then the nearer root numerator b - sqrt(D).
// ----------------------------------------------------------------------------
module scc_root (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           en,
	input  wire logic           in_valid,
	input  wire scc_pkg::geo_t  in_geo,
	input  wire logic [131:0]   in_disc,
	output logic                out_valid,
	output scc_pkg::root_t      out_root
);

	localparam int RS = scc_pkg::ROOT_STEPS;

	logic          v_s    [1:RS];
	scc_pkg::geo_t geo_s  [1:RS];
	logic [131:0]  rad_s  [1:RS-1];
	logic [66:0]   rem_s  [1:RS];
	logic [65:0]   sq_s   [1:RS];
	logic [132:0]  st     [1:RS];

	function automatic logic [132:0] root_step(logic [66:0] rem, logic [65:0] sq,
		logic [1:0] pair);
		logic [68:0] acc;
		logic [68:0] trial;
		acc   = {rem, pair};
		trial = {1'b0, sq, 2'b01};
		if (acc >= trial) begin
			return {67'(acc - trial), sq[64:0], 1'b1};
		end
		return {acc[66:0], sq[64:0], 1'b0};
	endfunction

	always_comb begin
		st[1] = root_step(67'd0, 66'd0, in_disc[131:130]);
		for (int k = 2; k <= RS; k++) begin
			st[k] = root_step(rem_s[k-1], sq_s[k-1], rad_s[k-1][131:130]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= RS; k++) begin
				v_s[k] <= 1'b0;
			end
			out_valid <= 1'b0;
		end else if (en) begin
			v_s[1] <= in_valid;
			for (int k = 2; k <= RS; k++) begin
				v_s[k] <= v_s[k-1];
			end
			out_valid <= v_s[RS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			geo_s[1] <= in_geo;
			rad_s[1] <= {in_disc[129:0], 2'b00};
			rem_s[1] <= st[1][132:66];
			sq_s[1]  <= st[1][65:0];
			for (int k = 2; k <= RS; k++) begin
				geo_s[k] <= geo_s[k-1];
				rem_s[k] <= st[k][132:66];
				sq_s[k]  <= st[k][65:0];
			end
			for (int k = 2; k <= RS - 1; k++) begin
				rad_s[k] <= {rad_s[k-1][129:0], 2'b00};
			end
			out_root.geo  <= geo_s[RS];
			out_root.near <= geo_s[RS].dot - sq_s[RS];
		end
	end

endmodule
`default_nettype wire

/* hdl/scc_contact.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Contact point
// Scales the direction by near/len2 with a rounded restoring divider, then
// forms the offset from the center and its squared length.
// ----------------------------------------------------------------------------
module scc_contact (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           en,
	input  wire logic           in_valid,
	input  wire scc_pkg::root_t in_root,
	output logic                out_valid,
	output scc_pkg::nrm_t       out_nrm,
	output logic [65:0]         out_q
);

	localparam int DS = scc_pkg::QUO_STEPS;

	logic [131:0]       prod_x, prod_y;
	logic               mv_s1, mv_s2;
	scc_pkg::root_t     mrt_s1, mrt_s2;

	logic               dv_s  [1:DS];
	scc_pkg::geo_t      dg_s  [1:DS];
	logic [65:0]        drx_s [1:DS];
	logic [65:0]        dry_s [1:DS];
	logic [33:0]        dqx_s [1:DS];
	logic [33:0]        dqy_s [1:DS];
	logic [33:0]        dlx_s [1:DS-1];
	logic [33:0]        dly_s [1:DS-1];
	logic [66:0]        stx   [1:DS];
	logic [66:0]        sty   [1:DS];

	logic               rnd_x, rnd_y;
	logic [33:0]        qx, qy;
	logic [32:0]        mx, my;

	logic               cv_s1, cv_s2, cv_s3;
	logic               miss_s1, miss_s2, miss_s3;
	logic signed [31:0] px_s1, py_s1, cx_s1, cy_s1;
	logic signed [31:0] px_s2, py_s2, px_s3, py_s3;
	logic signed [32:0] ox_s2, oy_s2;
	logic               nx_s3, ny_s3, zero_s3;
	logic [32:0]        mx_s3, my_s3;
	logic [65:0]        sqx_s3, sqy_s3;

	function automatic logic [66:0] quo_step(logic [65:0] rem, logic nb, logic [65:0] den);
		logic [66:0] acc;
		acc = {rem, nb};
		if (acc >= {1'b0, den}) begin
			return {66'(acc - {1'b0, den}), 1'b1};
		end
		return {acc[65:0], 1'b0};
	endfunction

	scc_mul u_mul_x (.clk(clk), .en(en), .x(in_root.near), .y(66'(in_root.geo.mag_dx)),
		.prod(prod_x));
	scc_mul u_mul_y (.clk(clk), .en(en), .x(in_root.near), .y(66'(in_root.geo.mag_dy)),
		.prod(prod_y));

	always_comb begin
		stx[1] = quo_step({1'b0, prod_x[98:34]}, prod_x[33], mrt_s2.geo.len2);
		sty[1] = quo_step({1'b0, prod_y[98:34]}, prod_y[33], mrt_s2.geo.len2);
		for (int k = 2; k <= DS; k++) begin
			stx[k] = quo_step(drx_s[k-1], dlx_s[k-1][33], dg_s[k-1].len2);
			sty[k] = quo_step(dry_s[k-1], dly_s[k-1][33], dg_s[k-1].len2);
		end
	end

	assign rnd_x = {drx_s[DS], 1'b0} >= {1'b0, dg_s[DS].len2};
	assign rnd_y = {dry_s[DS], 1'b0} >= {1'b0, dg_s[DS].len2};
	assign qx    = dqx_s[DS] + 34'(rnd_x);
	assign qy    = dqy_s[DS] + 34'(rnd_y);
	assign mx    = scc_pkg::mag33(ox_s2);
	assign my    = scc_pkg::mag33(oy_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mv_s1 <= 1'b0;
			mv_s2 <= 1'b0;
			for (int k = 1; k <= DS; k++) begin
				dv_s[k] <= 1'b0;
			end
			cv_s1     <= 1'b0;
			cv_s2     <= 1'b0;
			cv_s3     <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			mv_s1   <= in_valid;
			mv_s2   <= mv_s1;
			dv_s[1] <= mv_s2;
			for (int k = 2; k <= DS; k++) begin
				dv_s[k] <= dv_s[k-1];
			end
			cv_s1     <= dv_s[DS];
			cv_s2     <= cv_s1;
			cv_s3     <= cv_s2;
			out_valid <= cv_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mrt_s1 <= in_root;
			mrt_s2 <= mrt_s1;

			dg_s[1]  <= mrt_s2.geo;
			drx_s[1] <= stx[1][66:1];
			dry_s[1] <= sty[1][66:1];
			dqx_s[1] <= 34'(stx[1][0]);
			dqy_s[1] <= 34'(sty[1][0]);
			dlx_s[1] <= {prod_x[32:0], 1'b0};
			dly_s[1] <= {prod_y[32:0], 1'b0};
			for (int k = 2; k <= DS; k++) begin
				dg_s[k]  <= dg_s[k-1];
				drx_s[k] <= stx[k][66:1];
				dry_s[k] <= sty[k][66:1];
				dqx_s[k] <= {dqx_s[k-1][32:0], stx[k][0]};
				dqy_s[k] <= {dqy_s[k-1][32:0], sty[k][0]};
			end
			for (int k = 2; k <= DS - 1; k++) begin
				dlx_s[k] <= {dlx_s[k-1][32:0], 1'b0};
				dly_s[k] <= {dly_s[k-1][32:0], 1'b0};
			end

			miss_s1 <= dg_s[DS].miss;
			cx_s1   <= dg_s[DS].center_x;
			cy_s1   <= dg_s[DS].center_y;
			px_s1   <= dg_s[DS].start_x + (dg_s[DS].neg_dx ? -qx[31:0] : qx[31:0]);
			py_s1   <= dg_s[DS].start_y + (dg_s[DS].neg_dy ? -qy[31:0] : qy[31:0]);

			miss_s2 <= miss_s1;
			px_s2   <= px_s1;
			py_s2   <= py_s1;
			ox_s2   <= 33'(px_s1) - 33'(cx_s1);
			oy_s2   <= 33'(py_s1) - 33'(cy_s1);

			miss_s3 <= miss_s2;
			px_s3   <= px_s2;
			py_s3   <= py_s2;
			nx_s3   <= ox_s2[32];
			ny_s3   <= oy_s2[32];
			mx_s3   <= mx;
			my_s3   <= my;
			zero_s3 <= (ox_s2 == 33'sd0) && (oy_s2 == 33'sd0);
			sqx_s3  <= 66'(mx) * 66'(mx);
			sqy_s3  <= 66'(my) * 66'(my);

			out_nrm.miss      <= miss_s3;
			out_nrm.zero      <= zero_s3;
			out_nrm.contact_x <= px_s3;
			out_nrm.contact_y <= py_s3;
			out_nrm.neg_x     <= nx_s3;
			out_nrm.neg_y     <= ny_s3;
			out_nrm.mag_x     <= mx_s3;
			out_nrm.mag_y     <= my_s3;
			out_q             <= sqx_s3 + sqy_s3;
		end
	end

endmodule
`default_nettype wire

/* hdl/scc_normal.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Unit normal
// Length of the center offset by square root, then a rounded divide of each
// component, saturated to one. Drives the result register.
// ----------------------------------------------------------------------------
module scc_normal (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               en,
	input  wire logic               in_valid,
	input  wire scc_pkg::nrm_t      in_nrm,
	input  wire logic [65:0]        in_q,
	output logic                    out_valid,
	output logic                    hit,
	output logic signed [31:0]      contact_x,
	output logic signed [31:0]      contact_y,
	output logic signed [17:0]      normal_x,
	output logic signed [17:0]      normal_y
);

	localparam int LS = scc_pkg::LEN_STEPS;
	localparam int US = scc_pkg::UNIT_STEPS;

	logic          sv_s    [1:LS];
	scc_pkg::nrm_t sn_s    [1:LS];
	logic [97:0]   srad_s  [1:LS-1];
	logic [49:0]   srem_s  [1:LS];
	logic [48:0]   sroot_s [1:LS];
	logic [98:0]   sst     [1:LS];

	logic          uv_s  [1:US];
	scc_pkg::nrm_t un_s  [1:US];
	logic [48:0]   ul_s  [1:US];
	logic [48:0]   urx_s [1:US];
	logic [48:0]   ury_s [1:US];
	logic [17:0]   uqx_s [1:US];
	logic [17:0]   uqy_s [1:US];
	logic [49:0]   ustx  [1:US];
	logic [49:0]   usty  [1:US];

	logic          rnd_x, rnd_y;
	logic [18:0]   mqx, mqy, satx, saty;

	function automatic logic [98:0] len_step(logic [49:0] rem, logic [48:0] sq,
		logic [1:0] pair);
		logic [51:0] acc;
		logic [51:0] trial;
		acc   = {rem, pair};
		trial = {1'b0, sq, 2'b01};
		if (acc >= trial) begin
			return {50'(acc - trial), sq[47:0], 1'b1};
		end
		return {acc[49:0], sq[47:0], 1'b0};
	endfunction

	function automatic logic [49:0] unit_step(logic [48:0] rem, logic [48:0] den);
		logic [49:0] acc;
		acc = {rem, 1'b0};
		if (acc >= {1'b0, den}) begin
			return {49'(acc - {1'b0, den}), 1'b1};
		end
		return {acc[48:0], 1'b0};
	endfunction

	always_comb begin
		sst[1] = len_step(50'd0, 49'd0, in_q[65:64]);
		for (int k = 2; k <= LS; k++) begin
			sst[k] = len_step(srem_s[k-1], sroot_s[k-1], srad_s[k-1][97:96]);
		end
		ustx[1] = unit_step({2'b00, sn_s[LS].mag_x, 14'b0}, sroot_s[LS]);
		usty[1] = unit_step({2'b00, sn_s[LS].mag_y, 14'b0}, sroot_s[LS]);
		for (int k = 2; k <= US; k++) begin
			ustx[k] = unit_step(urx_s[k-1], ul_s[k-1]);
			usty[k] = unit_step(ury_s[k-1], ul_s[k-1]);
		end
	end

	assign rnd_x = {urx_s[US], 1'b0} >= {1'b0, ul_s[US]};
	assign rnd_y = {ury_s[US], 1'b0} >= {1'b0, ul_s[US]};
	assign mqx   = 19'(uqx_s[US]) + 19'(rnd_x);
	assign mqy   = 19'(uqy_s[US]) + 19'(rnd_y);
	assign satx  = (mqx > scc_pkg::UNIT_ONE) ? scc_pkg::UNIT_ONE : mqx;
	assign saty  = (mqy > scc_pkg::UNIT_ONE) ? scc_pkg::UNIT_ONE : mqy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= LS; k++) begin
				sv_s[k] <= 1'b0;
			end
			for (int k = 1; k <= US; k++) begin
				uv_s[k] <= 1'b0;
			end
			out_valid <= 1'b0;
		end else if (en) begin
			sv_s[1] <= in_valid;
			for (int k = 2; k <= LS; k++) begin
				sv_s[k] <= sv_s[k-1];
			end
			uv_s[1] <= sv_s[LS];
			for (int k = 2; k <= US; k++) begin
				uv_s[k] <= uv_s[k-1];
			end
			out_valid <= uv_s[US];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sn_s[1]    <= in_nrm;
			srad_s[1]  <= {in_q[63:0], 34'b0};
			srem_s[1]  <= sst[1][98:49];
			sroot_s[1] <= sst[1][48:0];
			for (int k = 2; k <= LS; k++) begin
				sn_s[k]    <= sn_s[k-1];
				srem_s[k]  <= sst[k][98:49];
				sroot_s[k] <= sst[k][48:0];
			end
			for (int k = 2; k <= LS - 1; k++) begin
				srad_s[k] <= {srad_s[k-1][95:0], 2'b00};
			end

			un_s[1]  <= sn_s[LS];
			ul_s[1]  <= sroot_s[LS];
			urx_s[1] <= ustx[1][49:1];
			ury_s[1] <= usty[1][49:1];
			uqx_s[1] <= 18'(ustx[1][0]);
			uqy_s[1] <= 18'(usty[1][0]);
			for (int k = 2; k <= US; k++) begin
				un_s[k]  <= un_s[k-1];
				ul_s[k]  <= ul_s[k-1];
				urx_s[k] <= ustx[k][49:1];
				ury_s[k] <= usty[k][49:1];
				uqx_s[k] <= {uqx_s[k-1][16:0], ustx[k][0]};
				uqy_s[k] <= {uqy_s[k-1][16:0], usty[k][0]};
			end

			if (un_s[US].miss) begin
				hit       <= 1'b0;
				contact_x <= 32'sd0;
				contact_y <= 32'sd0;
				normal_x  <= 18'sd0;
				normal_y  <= 18'sd0;
			end else begin
				hit       <= 1'b1;
				contact_x <= un_s[US].contact_x;
				contact_y <= un_s[US].contact_y;
				if (un_s[US].zero) begin
					normal_x <= 18'sd0;
					normal_y <= 18'sd0;
				end else begin
					normal_x <= un_s[US].neg_x ? -$signed(satx[17:0]) : $signed(satx[17:0]);
					normal_y <= un_s[US].neg_y ? -$signed(saty[17:0]) : $signed(saty[17:0]);
				end
			end
		end
	end

endmodule
`default_nettype wire

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Swept circle collision testbench
// Streams collision queries into the block: a directed set of edge cases first,
// then mostly well-formed random approach paths mixed with fully random items.
// A bit-exact predictor works out each expected hit, contact point and normal.
// Results are compared in order, while both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;

	typedef struct {
		logic signed [31:0] cx, cy, sx, sy, ex, ey;
		logic [30:0]        own_r, oth_r;
	} query_t;

	typedef struct {
		logic               hit;
		logic signed [31:0] px, py;
		logic signed [17:0] nx, ny;
	} answer_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [255:0] s_tdata = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [103:0] m_tdata;
	logic         m_tuser;

	query_t  pending_q[$];
	answer_t expected_q[$];
	query_t  cur;
	int      n_bad = 0;
	int      n_taken = 0;
	logic    hold = 1'b0;
	logic    taken = 1'b0;

	swept_circle_collision dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic logic [159:0] root_floor(logic [159:0] v);
		logic [159:0] r, t;
		r = '0;
		for (int i = 79; i >= 0; i--) begin
			t = r | (160'd1 << i);
			if (t * t <= v)
				r = t;
		end
		return r;
	endfunction

	function automatic logic [159:0] div_round(logic [159:0] num, logic [159:0] den);
		logic [159:0] q, rem;
		q = num / den;
		rem = num % den;
		if ((rem << 1) >= den)
			q = q + 1;
		return q;
	endfunction

	function automatic logic [159:0] abs_w(logic signed [159:0] v);
		return v < 0 ? -v : v;
	endfunction

	function automatic logic signed [17:0] unit_part(logic signed [159:0] n, logic [159:0] len);
		logic [159:0] m;
		m = div_round(abs_w(n) << 32, len);
		if (m > 160'd65536)
			m = 160'd65536;
		return n < 0 ? -18'(m) : 18'(m);
	endfunction

	function automatic answer_t predict_contact(query_t q);
		answer_t res;
		logic signed [159:0] dx, dy, rx, ry, bs, px, py, nx, ny;
		logic [159:0] rs, rel2, r2, c, a, b, d, s, u, lim, len;
		res = '{1'b0, '0, '0, '0, '0};
		dx = 160'(q.ex) - 160'(q.sx);
		dy = 160'(q.ey) - 160'(q.sy);
		rx = 160'(q.cx) - 160'(q.sx);
		ry = 160'(q.cy) - 160'(q.sy);
		rs = 160'(q.own_r) + 160'(q.oth_r);
		rel2 = rx * rx + ry * ry;
		r2 = rs * rs;
		if (rel2 < r2)
			return res;
		c = rel2 - r2;
		a = dx * dx + dy * dy;
		if (a == 0)
			return res;
		bs = dx * rx + dy * ry;
		if (bs < 0)
			return res;
		b = bs;
		if (b * b < a * c)
			return res;
		d = b * b - a * c;
		if (b > a) begin
			lim = b - a;
			if (lim * lim > d)
				return res;
		end
		s = root_floor(d);
		u = b - s;
		px = div_round(u * abs_w(dx), a);
		py = div_round(u * abs_w(dy), a);
		px = 160'(q.sx) + (dx < 0 ? -px : px);
		py = 160'(q.sy) + (dy < 0 ? -py : py);
		res.hit = 1'b1;
		res.px = px[31:0];
		res.py = py[31:0];
		nx = px - 160'(q.cx);
		ny = py - 160'(q.cy);
		if (nx != 0 || ny != 0) begin
			len = root_floor((nx * nx + ny * ny) << 32);
			res.nx = unit_part(nx, len);
			res.ny = unit_part(ny, len);
		end
		return res;
	endfunction

	function automatic logic [255:0] pack_query(query_t q);
		return {2'b00, q.ey, q.ex, q.sy, q.sx, q.oth_r, q.own_r, q.cy, q.cx};
	endfunction

	function automatic int phase_idle_tx();
		int ph;
		ph = (n_taken / 300) % 4;
		return (ph == 1) ? 65 : (ph == 3) ? 37 : 0;
	endfunction

	function automatic int phase_idle_rx();
		int ph;
		ph = (n_taken / 300) % 4;
		return (ph == 2) ? 65 : (ph == 3) ? 37 : 0;
	endfunction

	// sample handshakes
	always @(posedge clk) begin
		answer_t e;
		taken <= s_tvalid && s_tready;
		if (s_tvalid && s_tready) begin
			expected_q.push_back(predict_contact(cur));
			n_taken++;
		end
		if (m_tvalid && m_tready) begin
			if (expected_q.size() == 0) begin
				n_bad++;
				if (n_bad <= 10)
					$display("unexpected result: hit %0b data %h", m_tuser, m_tdata);
			end else begin
				e = expected_q.pop_front();
				if (m_tuser !== e.hit || m_tdata[31:0] !== e.px
						|| m_tdata[63:32] !== e.py
						|| m_tdata[81:64] !== e.nx || m_tdata[99:82] !== e.ny
						|| m_tdata[103:100] !== 4'd0) begin
					n_bad++;
					if (n_bad <= 10)
						$display({"mismatch: exp hit %0b p (%0d,%0d) n (%0d,%0d) ",
							"got hit %0b p (%0d,%0d) n (%0d,%0d)"},
							e.hit, e.px, e.py, e.nx, e.ny, m_tuser,
							$signed(m_tdata[31:0]), $signed(m_tdata[63:32]),
							$signed(m_tdata[81:64]), $signed(m_tdata[99:82]));
				end
			end
		end
	end

	// drive at the falling edge
	always @(negedge clk) begin
		if (arst_n) begin
			m_tready <= ($urandom_range(99) >= phase_idle_rx());
			if (!s_tvalid || taken) begin
				if (!hold && pending_q.size() > 0 && $urandom_range(99) >= phase_idle_tx()) begin
					cur = pending_q.pop_front();
					s_tdata <= pack_query(cur);
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	function automatic query_t rand_query();
		query_t q;
		q.cx = $urandom; q.cy = $urandom; q.sx = $urandom; q.sy = $urandom;
		q.ex = $urandom; q.ey = $urandom;
		q.own_r = 31'($urandom); q.oth_r = 31'($urandom);
		return q;
	endfunction

	function automatic query_t approach_query();
		query_t q;
		int sc, rr;
		sc = 1 << $urandom_range(12, 27);
		rr = $urandom_range(0, sc / 4);
		q.cx = $signed($urandom_range(0, 1 << 29)) - (1 << 28);
		q.cy = $signed($urandom_range(0, 1 << 29)) - (1 << 28);
		q.own_r = 31'($urandom_range(0, rr));
		q.oth_r = 31'($urandom_range(0, rr));
		q.sx = q.cx + $signed($urandom_range(0, 2 * sc)) - sc;
		q.sy = q.cy + $signed($urandom_range(0, 2 * sc)) - sc;
		q.ex = q.cx + $signed($urandom_range(0, sc)) - sc / 2;
		q.ey = q.cy + $signed($urandom_range(0, sc)) - sc / 2;
		if ($urandom_range(3) == 0) begin
			q.ex = q.sx + (q.ex - q.sx) / 4;
			q.ey = q.sy + (q.ey - q.sy) / 4;
		end
		return q;
	endfunction

	initial begin
		query_t q;
		q = '{cx: 0, cy: 0, sx: -65536, sy: 0, ex: 65536, ey: 0, own_r: 0, oth_r: 0};
		pending_q.push_back(q);                        // contact at the center
		q = '{cx: 0, cy: 0, sx: -327680, sy: 0, ex: 327680, ey: 0,
			own_r: 65536, oth_r: 65536};
		pending_q.push_back(q);                        // plain hit
		q.sx = -131072; q.ex = 0;
		pending_q.push_back(q);                        // start on the circle, inward
		q.sx = 0; q.ex = 65536;
		pending_q.push_back(q);                        // start inside
		q.sx = -327680; q.ex = -327680;
		pending_q.push_back(q);                        // zero length
		q.ex = -262144;
		pending_q.push_back(q);                        // root beyond one
		q.ex = -655360;
		pending_q.push_back(q);                        // moving away
		q.sy = 327680; q.ey = 327680; q.ex = 327680;
		pending_q.push_back(q);                        // passes wide
		q = '{cx: 32'h7fffffff, cy: 32'h7fffffff, sx: 32'h80000000, sy: 32'h80000000,
			ex: 32'h7fffffff, ey: 32'h7fffffff, own_r: 31'h7fffffff, oth_r: 31'h7fffffff};
		pending_q.push_back(q);
		q.own_r = 0; q.oth_r = 0;
		pending_q.push_back(q);
		q = '{cx: 32'h80000000, cy: 32'h7fffffff, sx: 32'h7fffffff, sy: 32'h80000000,
			ex: 32'h80000000, ey: 32'h7fffffff, own_r: 31'h7fffffff, oth_r: 0};
		pending_q.push_back(q);
		q.own_r = 0;
		pending_q.push_back(q);
		q = '{cx: 0, cy: 0, sx: 32'h80000000, sy: 0, ex: 32'h7fffffff, ey: 0,
			own_r: 1, oth_r: 0};
		pending_q.push_back(q);
		q = '{cx: 0, cy: 0, sx: 32'h80000000, sy: 32'h80000000, ex: 32'h7fffffff,
			ey: 32'h7fffffff, own_r: 31'h40000000, oth_r: 31'h3fffffff};
		pending_q.push_back(q);
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		wait (pending_q.size() == 0);
		@(negedge clk);
		hold = 1'b1;
		wait (!s_tvalid && expected_q.size() == 0);
		@(negedge clk);
		hold = 1'b0;
		for (int i = 0; i < 2000; i++)
			pending_q.push_back($urandom_range(4) == 0 ? rand_query() : approach_query());
		wait (pending_q.size() == 0);
		@(negedge clk);
		wait (!s_tvalid && expected_q.size() == 0);
		repeat (250) @(posedge clk);
		if (n_bad == 0 && expected_q.size() == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

	initial begin
		#2000000;
		$display("tb_top: errors");
		$finish;
	end

endmodule
